[hdl/dtf_pkg.sv]
// Shared types, character codes and weight helpers for the decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package dtf_pkg;

  // Default number format: Q31.32 with 16 guard bits in the fraction sum
  localparam int INT_BITS_DEF   = 31;
  localparam int FRAC_BITS_DEF  = 32;
  localparam int GUARD_BITS_DEF = 16;

  // Depth of the queue between the classifier and the accumulator
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Input item: one character
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } dtf_in_t;

  // Result item
  typedef struct packed {
    logic signed [63:0] value;
    logic               saturated;
  } dtf_out_t;

  // Character class found by the front end
  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_POINT,
    CLS_OTHER
  } dtf_class_t;

  // Classified item passed through the queue
  typedef struct packed {
    logic       first;
    dtf_class_t cls;
    logic [3:0] digit;
  } dtf_token_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_DONE,
    PH_LEAD,
    PH_INT,
    PH_FRAC
  } dtf_phase_t;

  // Number of fraction weights until the weight reaches zero, plus the zero entry
  function automatic int weight_count(int acc_bits);
    logic [63:0] w;
    int          n;
    w = (64'd1 << acc_bits) / 10;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (w != 64'd0) begin
        n++;
        w = w / 10;
      end
    end
    return n + 1;
  endfunction

  // Weight of fraction digit k: floor(2^acc_bits / 10^(k+1))
  function automatic logic [63:0] weight_at(int acc_bits, int k);
    logic [63:0] w;
    w = (64'd1 << acc_bits) / 10;
    for (int i = 0; i < k; i++) begin
      w = w / 10;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

[hdl/decimal_text_to_fixed.sv]
// Top level of the decimal text to signed fixed point converter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII character per item and returns one signed fixed-point
// number (INT_BITS integer bits, FRAC_BITS fraction bits, Q31.32 by default,
// sign-extended to 64 bits) when the first character that does not fit
// "blanks, optional sign, digits, optional point, digits" arrives; NUL ends
// a string this way. A first-marked item starts a new conversion and drops
// any unfinished one. The block takes one character per cycle: the front end
// registers the character class, a two-entry queue follows, and the back end
// does one multiply-by-ten on the integer part or one digit-times-weight add
// on the fraction part per cycle; fraction weights come from a constant
// table. An ending character passes the front-end register and the queue;
// its result is then registered and waits in an output register while later
// characters keep flowing; an ending character that reaches the back end while
// the previous result still waits stalls there until that result is taken.
// Integer overflow clamps the magnitude to all ones and sets saturated.
module decimal_text_to_fixed #(
  parameter int INT_BITS   = dtf_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF,
  parameter int GUARD_BITS = dtf_pkg::GUARD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             char_valid,
  output logic                  char_ready,
  input  wire dtf_pkg::dtf_in_t char_item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output dtf_pkg::dtf_out_t     result_item
);

  logic                tok_valid;
  logic                q_full;
  dtf_pkg::dtf_token_t tok;
  logic                q_valid;
  dtf_pkg::dtf_token_t q_token;
  logic                q_pop;

  dtf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .tok_valid  (tok_valid),
    .tok_ready  (!q_full),
    .tok        (tok)
  );

  dtf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (tok_valid),
    .push_token (tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_token (q_token)
  );

  dtf_back #(
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .GUARD_BITS (GUARD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_token      (q_token),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

`ifndef SYNTHESIS
  localparam logic [63:0] SatMagChk = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;

  // A clamped result carries the largest magnitude with either sign
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.saturated |->
      (result_item.value == SatMagChk || result_item.value == 64'd0 - SatMagChk))
    else $error("saturated result without full-scale value");

  // A new result only follows an item taken from the queue
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

  // The back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[hdl/dtf_queue.sv]
// Small FIFO of classified items between the front end and the accumulator.
`timescale 1ns / 1ps
`default_nettype none
module dtf_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire dtf_pkg::dtf_token_t push_token,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output dtf_pkg::dtf_token_t     head_token
);

  localparam int Depth  = dtf_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  dtf_pkg::dtf_token_t slots [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CountW-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CountW'(Depth));
  assign head_valid = (count != '0);
  assign head_token = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/dtf_front.sv]
// Front end: accepts characters and registers their class and digit value.
`timescale 1ns / 1ps
`default_nettype none
module dtf_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_ready,
  input  wire dtf_pkg::dtf_in_t    char_item,
  output logic                     tok_valid,
  input  wire logic                tok_ready,
  output dtf_pkg::dtf_token_t      tok
);

  dtf_pkg::dtf_token_t tok_next;
  logic [7:0]          digit_code;

  assign char_ready = !tok_valid || tok_ready;
  assign digit_code = char_item.ch - dtf_pkg::CH_ZERO;

  // Classify the character
  always_comb begin
    tok_next.first = char_item.first;
    tok_next.digit = digit_code[3:0];
    if (char_item.ch >= dtf_pkg::CH_ZERO && char_item.ch <= dtf_pkg::CH_NINE) begin
      tok_next.cls = dtf_pkg::CLS_DIGIT;
    end else if (char_item.ch == dtf_pkg::CH_SPACE ||
                 (char_item.ch >= dtf_pkg::CH_TAB && char_item.ch <= dtf_pkg::CH_CR)) begin
      tok_next.cls = dtf_pkg::CLS_BLANK;
    end else if (char_item.ch == dtf_pkg::CH_PLUS) begin
      tok_next.cls = dtf_pkg::CLS_PLUS;
    end else if (char_item.ch == dtf_pkg::CH_MINUS) begin
      tok_next.cls = dtf_pkg::CLS_MINUS;
    end else if (char_item.ch == dtf_pkg::CH_POINT) begin
      tok_next.cls = dtf_pkg::CLS_POINT;
    end else begin
      tok_next.cls = dtf_pkg::CLS_OTHER;
    end
  end

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (char_ready) begin
      tok_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      tok <= tok_next;
    end
  end

endmodule
`default_nettype wire

[hdl/dtf_back.sv]
// Back end: parser state, integer and fraction accumulators, result register.
`timescale 1ns / 1ps
`default_nettype none
module dtf_back #(
  parameter int INT_BITS   = dtf_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF,
  parameter int GUARD_BITS = dtf_pkg::GUARD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire dtf_pkg::dtf_token_t q_token,
  output logic                     q_pop,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output dtf_pkg::dtf_out_t        result_item
);

  localparam int AccBits  = FRAC_BITS + GUARD_BITS;
  localparam int NumW     = dtf_pkg::weight_count(AccBits);
  localparam int KW       = $clog2(NumW);
  localparam int ProdBits = INT_BITS + 4;
  localparam logic [63:0] SatMag = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;

  // Fraction weight table, last entry zero
  logic [AccBits-1:0] weight_rom [NumW];
  for (genvar g = 0; g < NumW; g++) begin : g_weight
    localparam logic [63:0] WFull = dtf_pkg::weight_at(AccBits, g);
    assign weight_rom[g] = WFull[AccBits-1:0];
  end

  // Parser state
  dtf_pkg::dtf_phase_t phase, phase_next;
  logic                negative, negative_next;
  logic [INT_BITS-1:0] int_accum, int_accum_next;
  logic [AccBits-1:0]  frac_accum, frac_accum_next;
  logic [KW-1:0]       frac_idx, frac_idx_next;
  logic                overflowed, overflowed_next;

  // State as seen by this item (fresh on a first-marked item)
  dtf_pkg::dtf_phase_t ph_e;
  logic                neg_e;
  logic [INT_BITS-1:0] int_e;
  logic [AccBits-1:0]  frac_e;
  logic [KW-1:0]       idx_e;
  logic                ovf_e;

  logic                go_int;
  logic                emit;
  logic [ProdBits-1:0] int_prod;
  logic [AccBits+3:0]  frac_prod;
  logic [AccBits+3:0]  frac_sum;
  logic [63:0]         mag;
  dtf_pkg::dtf_out_t   res_next;

  always_comb begin
    ph_e   = q_token.first ? dtf_pkg::PH_LEAD : phase;
    neg_e  = q_token.first ? 1'b0 : negative;
    int_e  = q_token.first ? '0 : int_accum;
    frac_e = q_token.first ? '0 : frac_accum;
    idx_e  = q_token.first ? '0 : frac_idx;
    ovf_e  = q_token.first ? 1'b0 : overflowed;
  end

  // Multiply-add datapaths
  assign int_prod  = {1'b0, int_e, 3'b000} + {3'b000, int_e, 1'b0} +
                     ProdBits'(q_token.digit);
  assign frac_prod = (AccBits + 4)'(weight_rom[idx_e]) * (AccBits + 4)'(q_token.digit);
  assign frac_sum  = frac_prod + (AccBits + 4)'(frac_e);

  // Result from the state before this item
  always_comb begin
    if (ovf_e) begin
      mag = SatMag;
    end else begin
      mag = 64'({int_e, frac_e[AccBits-1:GUARD_BITS]});
    end
    res_next.value     = neg_e ? (64'd0 - mag) : mag;
    res_next.saturated = ovf_e;
  end

  // Next state and emit decision
  always_comb begin
    phase_next      = ph_e;
    negative_next   = neg_e;
    int_accum_next  = int_e;
    frac_accum_next = frac_e;
    frac_idx_next   = idx_e;
    overflowed_next = ovf_e;
    emit            = 1'b0;
    go_int          = 1'b0;
    unique case (ph_e)
      dtf_pkg::PH_DONE: begin
        // idle: drop the item
      end
      dtf_pkg::PH_LEAD: begin
        case (q_token.cls) inside
          dtf_pkg::CLS_BLANK: begin
          end
          dtf_pkg::CLS_PLUS, dtf_pkg::CLS_MINUS: begin
            negative_next = (q_token.cls == dtf_pkg::CLS_MINUS);
            phase_next    = dtf_pkg::PH_INT;
          end
          default: begin
            phase_next = dtf_pkg::PH_INT;
            go_int     = 1'b1;
          end
        endcase
      end
      dtf_pkg::PH_INT: begin
        go_int = 1'b1;
      end
      dtf_pkg::PH_FRAC: begin
        if (q_token.cls == dtf_pkg::CLS_DIGIT) begin
          frac_accum_next = frac_sum[AccBits-1:0];
          if (idx_e != KW'(NumW - 1)) begin
            frac_idx_next = idx_e + 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (go_int) begin
      if (q_token.cls == dtf_pkg::CLS_DIGIT) begin
        if (ovf_e || int_prod[ProdBits-1:INT_BITS] != '0) begin
          overflowed_next = 1'b1;
          int_accum_next  = '1;
        end else begin
          int_accum_next = int_prod[INT_BITS-1:0];
        end
      end else if (q_token.cls == dtf_pkg::CLS_POINT) begin
        phase_next = dtf_pkg::PH_FRAC;
      end else begin
        emit = 1'b1;
      end
    end
    if (emit) begin
      phase_next = dtf_pkg::PH_DONE;
    end
  end

  // Take an item unless it would emit into a full result register
  assign q_pop = q_valid && (!emit || !result_valid || result_ready);

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dtf_pkg::PH_DONE;
      negative   <= 1'b0;
      int_accum  <= '0;
      frac_accum <= '0;
      frac_idx   <= '0;
      overflowed <= 1'b0;
    end else if (q_pop) begin
      phase      <= phase_next;
      negative   <= negative_next;
      int_accum  <= int_accum_next;
      frac_accum <= frac_accum_next;
      frac_idx   <= frac_idx_next;
      overflowed <= overflowed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      result_item <= res_next;
    end
  end

endmodule
`default_nettype wire

[verif/tb_decimal_text_to_fixed.sv]
// Self-checking testbench for the decimal text to fixed point converter.
`timescale 1ns / 1ps
module tb_decimal_text_to_fixed;

  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [63:0] INT_LIMIT    = (64'd1 << dtf_pkg::INT_BITS_DEF) - 64'd1;
  localparam logic [63:0] SAT_MAG      =
    (64'd1 << (dtf_pkg::INT_BITS_DEF + dtf_pkg::FRAC_BITS_DEF)) - 64'd1;
  localparam logic [63:0] WEIGHT_START =
    (64'd1 << (dtf_pkg::FRAC_BITS_DEF + dtf_pkg::GUARD_BITS_DEF)) / 64'd10;
  localparam logic [7:0]  CH_NUL       = 8'h00;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              char_valid   = 1'b0;
  logic              char_ready;
  dtf_pkg::dtf_in_t  char_item    = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  dtf_pkg::dtf_out_t result_item;

  // Parser state mirrored on the testbench side
  dtf_pkg::dtf_phase_t parse_phase = dtf_pkg::PH_DONE;
  logic                parse_neg   = 1'b0;
  logic [63:0]         whole_acc   = '0;
  logic [63:0]         frac_acc    = '0;
  logic [63:0]         frac_weight = WEIGHT_START;
  logic                whole_ovf   = 1'b0;

  dtf_pkg::dtf_out_t awaited_numbers[$];
  int       errors        = 0;
  int       fed_items     = 0;
  int       cycles        = 0;
  int       in_idle_pct   = 0;
  int       out_stall_pct = 0;
  int       stall_left    = 0;
  bit       fresh         = 1'b0;

  decimal_text_to_fixed u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always #10 clk = ~clk;

  // Abort a run that has not finished by LIMIT_CYCLES
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_decimal_text_to_fixed: errors");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left   <= $urandom_range(0, 14);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest pending number
  always @(posedge clk) begin : check_results
    dtf_pkg::dtf_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_numbers.size() == 0) begin
        $error("unexpected result: value %h saturated %b",
               result_item.value, result_item.saturated);
        errors++;
      end else begin
        want = awaited_numbers.pop_front();
        if (result_item.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, result_item.value);
          errors++;
        end
        if (result_item.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, result_item.saturated);
          errors++;
        end
      end
    end
  end

  // Advance the mirrored parser by one accepted character
  task automatic parse_char(input logic [7:0] c, input logic f);
    logic              is_digit;
    logic [63:0]       d;
    logic [63:0]       nxt;
    logic [63:0]       mag;
    dtf_pkg::dtf_out_t r;
    is_digit = (c >= dtf_pkg::CH_ZERO) && (c <= dtf_pkg::CH_NINE);
    d = is_digit ? 64'(c - dtf_pkg::CH_ZERO) : 64'd0;
    if (f) begin
      parse_phase = dtf_pkg::PH_LEAD;
      parse_neg   = 1'b0;
      whole_acc   = '0;
      frac_acc    = '0;
      frac_weight = WEIGHT_START;
      whole_ovf   = 1'b0;
    end else if (parse_phase == dtf_pkg::PH_DONE) begin
      return;
    end
    fed_items++;
    if (parse_phase == dtf_pkg::PH_LEAD) begin
      if (c == dtf_pkg::CH_SPACE || (c >= dtf_pkg::CH_TAB && c <= dtf_pkg::CH_CR)) return;
      parse_phase = dtf_pkg::PH_INT;
      if (c == dtf_pkg::CH_MINUS || c == dtf_pkg::CH_PLUS) begin
        parse_neg = (c == dtf_pkg::CH_MINUS);
        return;
      end
    end
    if (parse_phase == dtf_pkg::PH_INT) begin
      if (is_digit) begin
        nxt = whole_acc * 64'd10 + d;
        if (whole_ovf || nxt > INT_LIMIT) begin
          whole_ovf = 1'b1;
          whole_acc = INT_LIMIT;
        end else begin
          whole_acc = nxt;
        end
        return;
      end
      if (c == dtf_pkg::CH_POINT) begin
        parse_phase = dtf_pkg::PH_FRAC;
        return;
      end
    end else if (is_digit) begin
      frac_acc    = frac_acc + d * frac_weight;
      frac_weight = frac_weight / 64'd10;
      return;
    end
    // Any other character closes the number
    if (whole_ovf) mag = SAT_MAG;
    else mag = (whole_acc << dtf_pkg::FRAC_BITS_DEF) | (frac_acc >> dtf_pkg::GUARD_BITS_DEF);
    r.value     = parse_neg ? -mag : mag;
    r.saturated = whole_ovf;
    awaited_numbers.push_back(r);
    parse_phase = dtf_pkg::PH_DONE;
  endtask

  // Offer one item, hold it until taken, then predict
  task automatic send_char(input logic [7:0] c, input logic f);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= '{ch: c, first: f};
    do @(posedge clk); while (!char_ready);
    parse_char(c, f);
  endtask

  task automatic put(input logic [7:0] c);
    send_char(c, fresh);
    fresh = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    fresh = 1'b1;
    put_text(s);
    put(term);
  endtask

  task automatic idle_input();
    char_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_digit();
    return dtf_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Blanks, optional sign, digits, optional point and fraction, then a terminator if terminate is set
  task automatic send_random_number(input bit terminate);
    int n_lead;
    int n_int;
    int n_frac;
    n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    n_int  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 9);
    n_frac = $urandom_range(0, 20);
    fresh  = 1'b1;
    repeat (n_lead)
      put(($urandom_range(0, 1) == 0) ? dtf_pkg::CH_SPACE :
          8'($urandom_range(dtf_pkg::CH_TAB, dtf_pkg::CH_CR)));
    case ($urandom_range(0, 2))
      0: put(dtf_pkg::CH_MINUS);
      1: put(dtf_pkg::CH_PLUS);
      default: ;
    endcase
    repeat (n_int) put(rand_digit());
    if ($urandom_range(0, 1) == 1) begin
      put(dtf_pkg::CH_POINT);
      repeat (n_frac) put(rand_digit());
    end
    if (terminate) begin
      put(($urandom_range(0, 3) != 0) ? CH_NUL : 8'($urandom_range(0, 255)));
      // trailing characters after the result are dropped by the block
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
        put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_noise();
    fresh = 1'b1;
    repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    idle_input();
    while (awaited_numbers.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_and_empty();
    send_char(rand_digit(), 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("", CH_NUL);
    send_text("-", CH_NUL);
  endtask

  task automatic test_integers();
    send_text("0", CH_NUL);
    send_text("123", CH_NUL);
    send_text("2147483647", CH_NUL);
  endtask

  task automatic test_blanks_and_signs();
    fresh = 1'b1;
    put(dtf_pkg::CH_SPACE);
    for (int c = dtf_pkg::CH_TAB; c <= dtf_pkg::CH_CR; c++) put(8'(c));
    put_text("-42");
    put(CH_NUL);
    send_text("+7", CH_NUL);
    send_text("- 5", CH_NUL);
    send_text("++1", CH_NUL);
  endtask

  task automatic test_fractions();
    send_text("-45.5", CH_NUL);
    send_text("5.", CH_NUL);
    send_text(".", CH_NUL);
    send_text("1.2.3", CH_NUL);
    send_text("3.14159265358979323846264", CH_NUL);
  endtask

  task automatic test_saturation();
    send_text("2147483648", CH_NUL);
    send_text("-99999999999", CH_NUL);
  endtask

  task automatic test_terminators_and_restart();
    send_text("1", "x");
    send_text("12", 8'hFF);
    put(rand_digit());
    fresh = 1'b1;
    put_text("987");
    send_text("6", CH_NUL);
  endtask

  task automatic test_pause_until_drained();
    repeat (4) send_random_number(1'b1);
    wait_drained();
    repeat (4) send_random_number(1'b1);
  endtask

  task automatic test_random_mix(input int target);
    int pick;
    int strings;
    strings = 0;
    while (fed_items < target) begin
      // change idling every few strings so quiet stretches occur too
      if (strings % 8 == 0) begin
        in_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) send_random_number(1'b1);
      else if (pick < 87) send_random_number(1'b0);
      else send_noise();
      strings++;
    end
  endtask

  task automatic test_tail_no_idle(input int target);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    while (fed_items < target) send_random_number(1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    in_idle_pct   = 20;
    out_stall_pct = 20;
    test_idle_and_empty();
    test_integers();
    test_blanks_and_signs();
    test_fractions();
    test_saturation();
    test_terminators_and_restart();
    test_pause_until_drained();
    test_random_mix(950);
    test_tail_no_idle(1100);
    idle_input();

    // Let the last results drain, then look for strays
    repeat (2000) begin
      if (awaited_numbers.size() == 0) break;
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (awaited_numbers.size() != 0) begin
      $error("%0d results never arrived", awaited_numbers.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_decimal_text_to_fixed: clean");
    end else begin
      $display("tb_decimal_text_to_fixed: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dtf_pkg.sv
hdl/dtf_queue.sv
hdl/dtf_front.sv
hdl/dtf_back.sv
hdl/decimal_text_to_fixed.sv
verif/tb_decimal_text_to_fixed.sv
